// File: rtl/dmc_pkg.sv
// Shared constants and types for the distance-to-MIDI controller.
package dmc_pkg;

    localparam int DEF_FRACTION_BITS = 16;
    localparam int DEF_DISTANCE_BITS = 16;

    // operating modes
    localparam logic [1:0] MODE_CC    = 2'd0;
    localparam logic [1:0] MODE_BEND  = 2'd1;
    localparam logic [1:0] MODE_QUANT = 2'd2;
    localparam logic [1:0] MODE_FREE  = 2'd3;

    // configuration register indexes
    localparam logic [3:0] CFG_MODE     = 4'd0;
    localparam logic [3:0] CFG_CHANNEL  = 4'd1;
    localparam logic [3:0] CFG_CC_NUM   = 4'd2;
    localparam logic [3:0] CFG_MIN_DIST = 4'd3;
    localparam logic [3:0] CFG_MAX_DIST = 4'd4;
    localparam logic [3:0] CFG_LOW_NOTE = 4'd5;
    localparam logic [3:0] CFG_HIGH_NOTE = 4'd6;
    localparam logic [3:0] CFG_JITTER   = 4'd7;

    // register reset values
    localparam logic [1:0]  RST_MODE      = MODE_QUANT;
    localparam logic [3:0]  RST_CHANNEL   = 4'd0;
    localparam logic [6:0]  RST_CC_NUM    = 7'd1;
    localparam logic [15:0] RST_MIN_DIST  = 16'd30;
    localparam logic [15:0] RST_MAX_DIST  = 16'd400;
    localparam logic [6:0]  RST_LOW_NOTE  = 7'd68;
    localparam logic [6:0]  RST_HIGH_NOTE = 7'd82;
    localparam logic [15:0] RST_JITTER    = 16'd9830;
    localparam logic [6:0]  RST_CUR_NOTE  = 7'd61;

    // message opcodes (high nibble of status)
    localparam logic [3:0] OP_NOTE_OFF = 4'h8;
    localparam logic [3:0] OP_NOTE_ON  = 4'h9;
    localparam logic [3:0] OP_CC       = 4'hB;
    localparam logic [3:0] OP_BEND     = 4'hE;

    localparam logic [6:0]  NOTE_HOLD   = 7'd60;
    localparam logic [6:0]  VEL_ON      = 7'd127;
    localparam logic [6:0]  VEL_OFF     = 7'd0;
    localparam logic [13:0] BEND_CENTER = 14'd8192;

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] data1;
        logic [6:0] data2;
    } t_msg;

endpackage

// File: rtl/distance_to_midi_controller_core.sv
// Distance-to-MIDI controller: bit-serial normalizer and message sequencer.
//
// One sample is taken at a time. After acceptance the bit-serial divider
// forms the normalized distance, then the clamped value is latched, scaled,
// rounded and built into messages, and each of the zero to three messages
// is then shown on the output, held there while the output is stalled. The
// next sample is taken only in the idle state, so o_in_stall stays high
// until the last message of the sample is taken.
module distance_to_midi_controller_core
    import dmc_pkg::*;
#(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    parameter int DISTANCE_BITS = DEF_DISTANCE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_distance,
    input  logic        i_target_found,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_status_byte,
    output logic [6:0]  o_data1,
    output logic [6:0]  o_data2,
    output logic        o_last_of_run,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int F  = FRACTION_BITS;
    localparam int CW = $clog2(F + 2);
    localparam int JL = (F >= 16) ? F - 16 : 0;
    localparam int JR = (F < 16) ? 16 - F : 0;
    localparam logic [F:0] ONE_Q  = {1'b1, {F{1'b0}}};
    localparam logic [F:0] HALF_Q = ONE_Q >> 1;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_RND, S_BUILD, S_EMIT} t_state;

    t_state r_state;

    // configuration
    logic [1:0]  r_mode;
    logic [3:0]  r_channel;
    logic [6:0]  r_cc_num;
    logic [15:0] r_min_dist, r_max_dist;
    logic [6:0]  r_low_note, r_high_note;
    logic [15:0] r_jitter;

    // persistent state
    logic        r_bending, r_playing;
    logic [F:0]  r_bend_start;
    logic [6:0]  r_cur_note;

    // per-sample datapath
    logic          r_found, r_zero, r_ovf;
    logic [16:0]   r_rem;
    logic [F:0]    r_quo;
    logic [CW-1:0] r_bit;
    logic [F:0]    r_f;
    logic [F+6:0]  r_x;
    logic [F:0]    r_p;
    logic [6:0]    r_cc;
    logic [6:0]    r_note;
    logic          r_hit;
    t_msg          r_msg [3];
    logic [1:0]    r_cnt, r_idx;

    // accept-time distance prep
    logic [15:0] dist_m, diff;
    logic        le_min, ovf_now;
    always_comb begin
        dist_m  = 16'(i_distance[DISTANCE_BITS-1:0]);
        le_min  = dist_m <= r_min_dist;
        diff    = dist_m - r_min_dist;
        ovf_now = (r_max_dist == 16'd0) || ({1'b0, diff} >= {r_max_dist, 1'b0});
    end

    // one restoring-division step
    logic        div_ge;
    logic [16:0] div_sub;
    logic [F:0]  f_now;
    always_comb begin
        div_ge  = r_rem >= {1'b0, r_max_dist};
        div_sub = div_ge ? r_rem - {1'b0, r_max_dist} : r_rem;
        if (r_zero)
            f_now = '0;
        else if (r_ovf || (r_quo > ONE_Q))
            f_now = ONE_Q;
        else
            f_now = r_quo;
    end

    // scale: note value, bend offset, controller value
    logic signed [7:0]   span;
    logic signed [F+9:0] prod, x_full;
    logic [F:0]          bs_eff;
    logic signed [F+2:0] dif;
    logic signed [F+4:0] p3;
    logic [F:0]          p_clamp;
    logic [F+7:0]        cc_t;
    always_comb begin
        span    = $signed({1'b0, r_high_note}) - $signed({1'b0, r_low_note});
        prod    = $signed({1'b0, r_f}) * span;
        x_full  = $signed({3'b000, r_low_note, {F{1'b0}}}) + prod;
        bs_eff  = r_bending ? r_bend_start : r_f;
        dif     = $signed({2'b00, r_f}) - $signed({2'b00, bs_eff});
        p3      = (F+5)'(dif) + ((F+5)'(dif) <<< 1) + (F+5)'($signed({1'b0, HALF_Q}));
        if (p3 < 0)
            p_clamp = '0;
        else if (p3 > $signed((F+5)'(ONE_Q)))
            p_clamp = ONE_Q;
        else
            p_clamp = p3[F:0];
        cc_t    = {r_f, 7'b0} - {7'b0, r_f};
    end

    // round and test hysteresis window
    logic [F+7:0] jq, hx, up_s, dn_s;
    logic         dn_ok, hit_now;
    always_comb begin
        if (F >= 16)
            jq = (F+8)'(r_jitter) << JL;
        else
            jq = (F+8)'(r_jitter >> JR);
        hx      = (F+8)'(r_x) + (F+8)'(HALF_Q);
        up_s    = hx + jq;
        dn_ok   = hx >= jq;
        dn_s    = hx - jq;
        hit_now = (up_s[F+7:F] == {1'b0, r_cur_note})
               || (dn_ok && (dn_s[F+7:F] == {1'b0, r_cur_note}));
    end

    function automatic logic [13:0] bend_code(input logic [F+1:0] p2);
        logic [F+15:0] s;
        s = {p2, 14'b0} - (F+16)'(p2) + (F+16)'(ONE_Q);
        return s[F+14:F+1];
    endfunction

    // assemble the messages of this sample and the next persistent state
    logic [F+7:0] p2_free;
    logic [13:0]  v_bend, v_free;
    t_msg         n_msg [3];
    logic [1:0]   n_cnt;
    logic         n_bending, n_playing;
    logic [F:0]   n_bend_start;
    logic [6:0]   n_cur_note;
    always_comb begin
        p2_free = (F+8)'(ONE_Q) + (F+8)'(r_x) - {1'b0, r_note, {F{1'b0}}};
        v_bend  = bend_code({r_p, 1'b0});
        v_free  = bend_code(p2_free[F+1:0]);
        for (int i = 0; i < 3; i++) n_msg[i] = '0;
        n_cnt        = 2'd0;
        n_bending    = r_bending;
        n_playing    = r_playing;
        n_bend_start = r_bend_start;
        n_cur_note   = r_cur_note;
        case (r_mode)
            MODE_CC: begin
                if (r_found) begin
                    n_msg[0] = '{{OP_CC, r_channel}, r_cc_num, r_cc};
                    n_cnt    = 2'd1;
                end
            end
            MODE_BEND: begin
                if (r_found) begin
                    if (!r_bending) begin
                        n_msg[0]     = '{{OP_NOTE_ON, r_channel}, NOTE_HOLD, VEL_ON};
                        n_msg[1]     = '{{OP_BEND, r_channel}, v_bend[6:0], v_bend[13:7]};
                        n_cnt        = 2'd2;
                        n_bending    = 1'b1;
                        n_bend_start = r_f;
                    end else begin
                        n_msg[0] = '{{OP_BEND, r_channel}, v_bend[6:0], v_bend[13:7]};
                        n_cnt    = 2'd1;
                    end
                end else if (r_bending) begin
                    n_msg[0]  = '{{OP_BEND, r_channel}, BEND_CENTER[6:0], BEND_CENTER[13:7]};
                    n_msg[1]  = '{{OP_NOTE_OFF, r_channel}, NOTE_HOLD, VEL_OFF};
                    n_cnt     = 2'd2;
                    n_bending = 1'b0;
                end
            end
            default: begin
                if (r_found) begin
                    if (!r_playing) begin
                        n_msg[0]   = '{{OP_NOTE_ON, r_channel}, r_note, VEL_ON};
                        n_cnt      = 2'd1;
                        n_cur_note = r_note;
                        n_playing  = 1'b1;
                    end else if ((r_note != r_cur_note)
                                 && ((r_mode == MODE_FREE) || !r_hit)) begin
                        n_msg[0]   = '{{OP_NOTE_ON, r_channel}, r_note, VEL_ON};
                        n_msg[1]   = '{{OP_NOTE_OFF, r_channel}, r_cur_note, VEL_OFF};
                        n_cnt      = 2'd2;
                        n_cur_note = r_note;
                    end
                    if (r_mode == MODE_FREE) begin
                        n_msg[n_cnt] = '{{OP_BEND, r_channel}, v_free[6:0], v_free[13:7]};
                        n_cnt        = n_cnt + 2'd1;
                    end
                end else if (r_playing) begin
                    n_msg[0]  = '{{OP_NOTE_OFF, r_channel}, r_cur_note, VEL_OFF};
                    n_cnt     = 2'd1;
                    n_playing = 1'b0;
                end
            end
        endcase
    end

    // sequencer, datapath registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= RST_MODE;
            r_channel    <= RST_CHANNEL;
            r_cc_num     <= RST_CC_NUM;
            r_min_dist   <= RST_MIN_DIST;
            r_max_dist   <= RST_MAX_DIST;
            r_low_note   <= RST_LOW_NOTE;
            r_high_note  <= RST_HIGH_NOTE;
            r_jitter     <= RST_JITTER;
            r_bending    <= 1'b0;
            r_playing    <= 1'b0;
            r_bend_start <= HALF_Q;
            r_cur_note   <= RST_CUR_NOTE;
            r_cnt        <= 2'd0;
            r_idx        <= 2'd0;
            r_bit        <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MODE:      r_mode      <= i_cfg_data[1:0];
                    CFG_CHANNEL:   r_channel   <= i_cfg_data[3:0];
                    CFG_CC_NUM:    r_cc_num    <= i_cfg_data[6:0];
                    CFG_MIN_DIST:  r_min_dist  <= i_cfg_data;
                    CFG_MAX_DIST:  r_max_dist  <= i_cfg_data;
                    CFG_LOW_NOTE:  r_low_note  <= i_cfg_data[6:0];
                    CFG_HIGH_NOTE: r_high_note <= i_cfg_data[6:0];
                    CFG_JITTER:    r_jitter    <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_found <= i_target_found;
                        r_zero  <= le_min;
                        r_ovf   <= ovf_now;
                        r_rem   <= {1'b0, diff};
                        r_quo   <= '0;
                        r_bit   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // shift in one quotient bit per cycle
                    r_quo <= {r_quo[F-1:0], div_ge};
                    r_rem <= {div_sub[15:0], 1'b0};
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == CW'(F)) r_state <= S_MUL;
                end
                S_MUL: begin
                    r_f     <= f_now;
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_x     <= x_full[F+6:0];
                    r_p     <= p_clamp;
                    r_cc    <= cc_t[F+6:F];
                    r_bit   <= '0;
                    r_state <= S_BUILD;
                end
                S_BUILD: begin
                    r_note  <= hx[F+6:F];
                    r_hit   <= hit_now;
                    r_state <= S_EMIT;
                    r_idx   <= 2'd0;
                    r_cnt   <= 2'd0;
                    r_bit   <= '0;
                    if (r_bit == '0) begin
                        // first pass only latches rounding; hold for build
                        r_bit   <= CW'(1);
                        r_state <= S_BUILD;
                    end else begin
                        for (int i = 0; i < 3; i++) r_msg[i] <= n_msg[i];
                        r_cnt        <= n_cnt;
                        r_bending    <= n_bending;
                        r_playing    <= n_playing;
                        r_bend_start <= n_bend_start;
                        r_cur_note   <= n_cur_note;
                        if (n_cnt == 2'd0) r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (!i_out_stall) begin
                        r_idx <= r_idx + 2'd1;
                        if (r_idx == r_cnt - 2'd1) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = (r_state == S_EMIT);
    assign o_status_byte = r_msg[r_idx].status;
    assign o_data1       = r_msg[r_idx].data1;
    assign o_data2       = r_msg[r_idx].data2;
    assign o_last_of_run = (r_idx == r_cnt - 2'd1);

    // a request is only on the output while the input side is held off
    a_busy_when_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("output valid while input open");

    // the message pointer stays inside the built list
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_idx < r_cnt)) else $error("message index out of range");

    // the divider never runs past its last quotient bit
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_bit <= CW'(F))) else $error("divider overrun");

endmodule

// File: tb/distance_to_midi_controller_core_test.sv
// Self-checking testbench for the distance-to-MIDI controller core.
`timescale 1ns / 100ps

module distance_to_midi_controller_core_test
    import dmc_pkg::*;
();

    localparam longint ONE_Q  = 64'sd1 << 16;
    localparam longint HALF_Q = 64'sd1 << 15;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        logic [7:0] status;
        logic [6:0] data1;
        logic [6:0] data2;
        logic       last;
    } t_midi_msg;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] distance = '0;
    logic        target_found = 1'b0;
    logic        o_out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  o_status_byte;
    logic [6:0]  o_data1;
    logic [6:0]  o_data2;
    logic        o_last_of_run;
    logic        cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    distance_to_midi_controller_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_distance     (distance),
        .i_target_found (target_found),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_status_byte  (o_status_byte),
        .o_data1        (o_data1),
        .o_data2        (o_data2),
        .o_last_of_run  (o_last_of_run),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    // predictor copy of registers and state
    logic [1:0]  m_mode;
    logic [3:0]  m_channel;
    logic [6:0]  m_cc_num;
    logic [15:0] m_min_dist, m_max_dist;
    logic [6:0]  m_low_note, m_high_note;
    logic [15:0] m_jitter;
    logic        m_bending, m_playing;
    longint      m_bend_start;
    logic [6:0]  m_cur_note;

    t_midi_msg midi_due[$];
    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // queue one predicted message on the configured channel
    function automatic void push_msg(logic [3:0] op, logic [6:0] d1, logic [6:0] d2);
        t_midi_msg m;
        m.status = {op, m_channel};
        m.data1  = d1;
        m.data2  = d2;
        m.last   = 1'b0;
        midi_due.push_back(m);
    endfunction

    function automatic void push_bend(longint p2);
        longint v;
        v = (p2 * 16383 + (64'sd1 << 16)) >>> 17;
        push_msg(OP_BEND, 7'(v), 7'(v >>> 7));
    endfunction

    function automatic longint norm_distance(logic [15:0] d);
        longint q;
        if (d <= m_min_dist) return 0;
        if (m_max_dist == 0) return ONE_Q;
        q = ((longint'(d) - longint'(m_min_dist)) <<< 16) / longint'(m_max_dist);
        return (q > ONE_Q) ? ONE_Q : q;
    endfunction

    function automatic longint round_half(longint x);
        longint y;
        y = x + HALF_Q;
        if (y < 0) return -1;
        return y >>> 16;
    endfunction

    // compute the messages one accepted sample causes
    function automatic void predict_midi(logic [15:0] d, logic found);
        longint f, p, x, note, jq, p2;
        int n0;
        logic change;
        n0 = midi_due.size();
        f = norm_distance(d);
        if (m_mode == MODE_CC) begin
            if (found) push_msg(OP_CC, m_cc_num, 7'((f * 127) >>> 16));
        end else if (m_mode == MODE_BEND) begin
            if (found) begin
                if (!m_bending) begin
                    push_msg(OP_NOTE_ON, NOTE_HOLD, VEL_ON);
                    m_bending = 1'b1;
                    m_bend_start = f;
                end
                p = (f - m_bend_start) * 3 + HALF_Q;
                if (p < 0) p = 0;
                if (p > ONE_Q) p = ONE_Q;
                push_bend(p * 2);
            end else if (m_bending) begin
                push_bend(ONE_Q);
                push_msg(OP_NOTE_OFF, NOTE_HOLD, VEL_OFF);
                m_bending = 1'b0;
            end
        end else begin
            if (found) begin
                x = f * (longint'(m_high_note) - longint'(m_low_note))
                    + (longint'(m_low_note) <<< 16);
                note = round_half(x);
                if (!m_playing) begin
                    m_cur_note = note[6:0];
                    m_playing = 1'b1;
                    push_msg(OP_NOTE_ON, 7'(note), VEL_ON);
                end else if (note != longint'(m_cur_note)) begin
                    change = (m_mode == MODE_FREE);
                    if (m_mode == MODE_QUANT) begin
                        jq = longint'(m_jitter);
                        change = round_half(x + jq) != longint'(m_cur_note)
                              && round_half(x - jq) != longint'(m_cur_note);
                    end
                    if (change) begin
                        push_msg(OP_NOTE_ON, 7'(note), VEL_ON);
                        push_msg(OP_NOTE_OFF, m_cur_note, VEL_OFF);
                        m_cur_note = note[6:0];
                    end
                end
                if (m_mode == MODE_FREE) begin
                    p2 = ONE_Q + (x - (note <<< 16));
                    if (p2 < 0) p2 = 0;
                    push_bend(p2);
                end
            end else if (m_playing) begin
                push_msg(OP_NOTE_OFF, m_cur_note, VEL_OFF);
                m_playing = 1'b0;
            end
        end
        if (midi_due.size() > n0) midi_due[midi_due.size() - 1].last = 1'b1;
    endfunction

    // compare each taken message against the oldest prediction
    always @(posedge i_clk) begin
        t_midi_msg m;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (midi_due.size() == 0) begin
                $error("unexpected message status=%h", o_status_byte);
                fail_count++;
            end else begin
                m = midi_due.pop_front();
                if (o_status_byte !== m.status) begin
                    $error("status_byte exp %h got %h", m.status, o_status_byte);
                    fail_count++;
                end
                if (o_data1 !== m.data1) begin
                    $error("data1 exp %0d got %0d", m.data1, o_data1);
                    fail_count++;
                end
                if (o_data2 !== m.data2) begin
                    $error("data2 exp %0d got %0d", m.data2, o_data2);
                    fail_count++;
                end
                if (o_last_of_run !== m.last) begin
                    $error("last_of_run exp %0d got %0d", m.last, o_last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // drive receiver stall: forced hold-off first, else random
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                || (cfg_valid && o_cfg_ready) || hold_left > 0) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // offer one sample request, with a random gap first
    task automatic send_sample(logic [15:0] d, logic found);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid     <= 1'b1;
        distance     <= d;
        target_found <= found;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        predict_midi(d, found);
    endtask

    // stop offering and wait until every predicted message is out
    task automatic drain_block();
        in_valid <= 1'b0;
        while (midi_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MODE:      m_mode      = val[1:0];
            CFG_CHANNEL:   m_channel   = val[3:0];
            CFG_CC_NUM:    m_cc_num    = val[6:0];
            CFG_MIN_DIST:  m_min_dist  = val;
            CFG_MAX_DIST:  m_max_dist  = val;
            CFG_LOW_NOTE:  m_low_note  = val[6:0];
            CFG_HIGH_NOTE: m_high_note = val[6:0];
            CFG_JITTER:    m_jitter    = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // distance near the configured window, sometimes any value
    function automatic logic [15:0] pick_distance();
        int lo, hi;
        if ($urandom_range(9) == 0) return 16'($urandom);
        lo = (m_min_dist > 50) ? m_min_dist - 50 : 0;
        hi = int'(m_min_dist) + int'(m_max_dist) + 50;
        if (hi > 65535) hi = 65535;
        return 16'($urandom_range(hi, lo));
    endfunction

    task automatic random_config();
        drain_block();
        write_reg(CFG_MODE, 16'($urandom_range(3)));
        write_reg(CFG_CHANNEL, 16'($urandom_range(15)));
        write_reg(CFG_CC_NUM, 16'($urandom_range(127)));
        write_reg(CFG_MIN_DIST, ($urandom_range(3) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(300)));
        write_reg(CFG_MAX_DIST, ($urandom_range(4) == 0) ? 16'($urandom_range(65535, 1))
                                                        : 16'($urandom_range(2000, 1)));
        write_reg(CFG_LOW_NOTE, 16'($urandom_range(127)));
        write_reg(CFG_HIGH_NOTE, 16'($urandom_range(127)));
        write_reg(CFG_JITTER, ($urandom_range(3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(40000)));
    endtask

    // runs of target-present samples closed by a lost target
    task automatic random_samples(int count);
        for (int k = 0; k < count; k++) begin
            send_sample(pick_distance(), ($urandom_range(99) < 82));
        end
    endtask

    // reset values: quantized notes on channel 0
    task automatic test_defaults();
        send_sample(16'd30, 1'b1);
        send_sample(16'd430, 1'b1);
        send_sample(16'd232, 1'b1);
        send_sample(16'd0, 1'b0);
        send_sample(16'd0, 1'b0);
    endtask

    task automatic test_cc_mode();
        drain_block();
        write_reg(CFG_MODE, 16'(MODE_CC));
        write_reg(CFG_CHANNEL, 16'd15);
        write_reg(CFG_CC_NUM, 16'd127);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'd0, 1'b1);
        send_sample(16'd200, 1'b0);
        drain_block();
        write_reg(CFG_CC_NUM, 16'd0);
        write_reg(4'd15, 16'hFFFF);
        send_sample(16'd215, 1'b1);
    endtask

    task automatic test_bend_mode();
        drain_block();
        write_reg(CFG_MODE, 16'(MODE_BEND));
        write_reg(CFG_CHANNEL, 16'd0);
        send_sample(16'd200, 1'b1);
        send_sample(16'd430, 1'b1);
        send_sample(16'd0, 1'b1);
        send_sample(16'd0, 1'b0);
        send_sample(16'd0, 1'b0);
    endtask

    // zero divisor, inverted range, jitter extremes, free notes
    task automatic test_note_edges();
        drain_block();
        write_reg(CFG_MODE, 16'(MODE_FREE));
        write_reg(CFG_MAX_DIST, 16'd0);
        write_reg(CFG_LOW_NOTE, 16'd127);
        write_reg(CFG_HIGH_NOTE, 16'd0);
        send_sample(16'd31, 1'b1);
        send_sample(16'd30, 1'b1);
        send_sample(16'd0, 1'b0);
        drain_block();
        write_reg(CFG_MODE, 16'(MODE_QUANT));
        write_reg(CFG_MAX_DIST, 16'hFFFF);
        write_reg(CFG_MIN_DIST, 16'd0);
        write_reg(CFG_JITTER, 16'hFFFF);
        send_sample(16'd0, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        drain_block();
        write_reg(CFG_JITTER, 16'd0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h2000, 1'b1);
        drain_block();
        write_reg(CFG_MIN_DIST, 16'hFFFF);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0000, 1'b0);
    endtask

    // hold the receiver off while the sender keeps offering
    task automatic test_backpressure();
        random_config();
        hold_left = 400;
        random_samples(10);
        drain_block();
    endtask

    task automatic test_random_phases();
        int send_pct[3] = '{19, 87, 0};
        int recv_pct[3] = '{87, 19, 0};
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = send_pct[ph];
            recv_idle_pct = recv_pct[ph];
            for (int c = 0; c < 4; c++) begin
                random_config();
                random_samples(20);
            end
        end
    endtask

    initial begin
        m_mode = RST_MODE; m_channel = RST_CHANNEL; m_cc_num = RST_CC_NUM;
        m_min_dist = RST_MIN_DIST; m_max_dist = RST_MAX_DIST;
        m_low_note = RST_LOW_NOTE; m_high_note = RST_HIGH_NOTE; m_jitter = RST_JITTER;
        m_bending = 1'b0; m_bend_start = HALF_Q; m_playing = 1'b0;
        m_cur_note = RST_CUR_NOTE;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_cc_mode();
        test_bend_mode();
        test_note_edges();
        test_backpressure();
        test_random_phases();
        drain_block();

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: distance_to_midi_controller_core.f
rtl/dmc_pkg.sv
rtl/distance_to_midi_controller_core.sv
tb/distance_to_midi_controller_core_test.sv
